>>> hw/rtl/fixed_point_to_decimal_digits_macros.svh
// assertion macros for the fixed-point to decimal digit converter
// expects clk_i and rst_ni in the scope of each use
`ifndef FIXED_POINT_TO_DECIMAL_DIGITS_MACROS_SVH
`define FIXED_POINT_TO_DECIMAL_DIGITS_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define FPTD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define FPTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fptd_pkg.sv
// shared constants, types and digit functions of the decimal digit converter
// no dependencies
package fptd_pkg;

  localparam int INT_DIGITS    = 16;
  localparam int FRAC_DIGITS   = 8;
  localparam int FRAC_BITS     = 12;
  localparam int VALUE_BITS    = 63;
  localparam int INT_BITS      = VALUE_BITS - FRAC_BITS;  // 51
  localparam int INT_BCD_BITS  = 4 * INT_DIGITS;
  localparam int FRAC_BCD_BITS = 4 * FRAC_DIGITS;
  localparam int FRAC_BIN_BITS = 27;                       // scaled fraction below 1e8
  localparam int INT_LEN_BITS  = 5;
  localparam int FRAC_LEN_BITS = 4;

  // double dabble pipeline shape
  localparam int DD_STAGES      = 7;
  localparam int INT_STEPS      = (INT_BITS + DD_STAGES - 1) / DD_STAGES;       // 8
  localparam int FRAC_STEPS     = (FRAC_BIN_BITS + DD_STAGES - 1) / DD_STAGES;  // 4
  localparam int INT_PAD_BITS   = INT_STEPS * DD_STAGES;
  localparam int FRAC_PAD_BITS  = FRAC_STEPS * DD_STAGES;

  localparam int                     PROD_BITS  = 31;
  localparam logic [PROD_BITS-1:0]   FRAC_SCALE = PROD_BITS'(100000000);

  typedef struct packed {
    logic [INT_PAD_BITS-1:0]  ibin;
    logic [INT_BCD_BITS-1:0]  ibcd;
    logic [FRAC_PAD_BITS-1:0] fbin;
    logic [FRAC_BCD_BITS-1:0] fbcd;
  } work_t;

  // one double dabble step on the integer digits
  function automatic logic [INT_BCD_BITS-1:0] dd_int_step(
    input logic [INT_BCD_BITS-1:0] bcd,
    input logic                    bit_in
  );
    logic [INT_BCD_BITS-1:0] adj;
    adj = bcd;
    for (int d = 0; d < INT_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[INT_BCD_BITS-2:0], bit_in};
  endfunction

  // one double dabble step on the fraction digits
  function automatic logic [FRAC_BCD_BITS-1:0] dd_frac_step(
    input logic [FRAC_BCD_BITS-1:0] bcd,
    input logic                     bit_in
  );
    logic [FRAC_BCD_BITS-1:0] adj;
    adj = bcd;
    for (int d = 0; d < FRAC_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[FRAC_BCD_BITS-2:0], bit_in};
  endfunction

endpackage

>>> hw/rtl/fptd_frac_scale.sv
// entry stage: splits the value and scales the fraction nibbles to 1e8
// depends on fptd_pkg
module fptd_frac_scale import fptd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output work_t                 data_o
);

  logic [PROD_BITS-1:0]     prod_lo, prod_mid, prod_hi;
  logic [FRAC_BIN_BITS-1:0] frac_sum;
  work_t                    data_d, data_q;
  logic                     valid_q;

  // each nibble scaled and truncated on its own
  assign prod_lo  = PROD_BITS'(value_i[3:0])  * FRAC_SCALE;
  assign prod_mid = PROD_BITS'(value_i[7:4])  * FRAC_SCALE;
  assign prod_hi  = PROD_BITS'(value_i[11:8]) * FRAC_SCALE;

  // sum stays below 1e8, no wrap needed
  assign frac_sum = FRAC_BIN_BITS'(prod_lo[PROD_BITS-1:12])
                  + FRAC_BIN_BITS'(prod_mid[PROD_BITS-1:8])
                  + FRAC_BIN_BITS'(prod_hi[PROD_BITS-1:4]);

  always_comb begin
    data_d.ibin = INT_PAD_BITS'(value_i[VALUE_BITS-1:FRAC_BITS]);
    data_d.ibcd = '0;
    data_d.fbin = FRAC_PAD_BITS'(frac_sum);
    data_d.fbcd = '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/fptd_dd_stage.sv
// one double dabble stage: a slice of integer and fraction bits per beat
// depends on fptd_pkg
module fptd_dd_stage import fptd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  work_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output work_t data_o
);

  work_t data_d, data_q;
  logic  valid_q;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < INT_STEPS; s++) begin
      data_d.ibcd = dd_int_step(data_d.ibcd, data_d.ibin[INT_PAD_BITS-1]);
      data_d.ibin = data_d.ibin << 1;
    end
    for (int s = 0; s < FRAC_STEPS; s++) begin
      data_d.fbcd = dd_frac_step(data_d.fbcd, data_d.fbin[FRAC_PAD_BITS-1]);
      data_d.fbin = data_d.fbin << 1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/fptd_out_stage.sv
// output stage: integer digit count, fraction precision cut, result register
// depends on fptd_pkg
module fptd_out_stage import fptd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  work_t                    data_i,
  input  logic [FRAC_LEN_BITS-1:0] frac_cfg_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [INT_BCD_BITS-1:0]  int_digits_o,
  output logic [INT_LEN_BITS-1:0]  int_length_o,
  output logic [FRAC_BCD_BITS-1:0] frac_digits_o,
  output logic [FRAC_LEN_BITS-1:0] frac_length_o
);

  logic [INT_LEN_BITS-1:0]  ilen_d, ilen_q;
  logic [FRAC_LEN_BITS-1:0] flen_d, flen_q;
  logic [FRAC_BCD_BITS-1:0] fmask, fbcd_d, fbcd_q;
  logic [INT_BCD_BITS-1:0]  ibcd_q;
  logic                     valid_q;

  // highest nonzero digit sets the count, zero still shows one digit
  always_comb begin
    ilen_d = INT_LEN_BITS'(1);
    for (int d = 0; d < INT_DIGITS; d++) begin
      if (data_i.ibcd[4*d +: 4] != 4'd0) begin
        ilen_d = INT_LEN_BITS'(d + 1);
      end
    end
  end

  assign flen_d = (frac_cfg_i > FRAC_LEN_BITS'(FRAC_DIGITS)) ?
                  FRAC_LEN_BITS'(FRAC_DIGITS) : frac_cfg_i;
  // keep the leading flen digits
  assign fmask  = ~({FRAC_BCD_BITS{1'b1}} >> (6'(flen_d) << 2));
  assign fbcd_d = data_i.fbcd & fmask;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ibcd_q <= data_i.ibcd;
      ilen_q <= ilen_d;
      fbcd_q <= fbcd_d;
      flen_q <= flen_d;
    end
  end

  assign valid_o       = valid_q;
  assign int_digits_o  = ibcd_q;
  assign int_length_o  = ilen_q;
  assign frac_digits_o = fbcd_q;
  assign frac_length_o = flen_q;

endmodule

>>> hw/rtl/fixed_point_to_decimal_digits.sv
// top level of the fixed-point to decimal digit converter
// depends on fptd_pkg, fptd_frac_scale, fptd_dd_stage, fptd_out_stage and the macro header

// Converts a non-negative 63-bit fixed-point value (12 fraction bits) into
// decimal digits. The integer part comes out as 16 BCD digits, least
// significant digit in the low nibble, with a count of significant digits
// (at least 1, so zero reads as a single 0). The fraction is formed by
// scaling each of its three nibbles by 100000000, truncating each product
// and summing; its 8 BCD digits come out first digit in the high nibble and
// are cut to the fraction_digits setting (0 gives an empty fraction, 9 to 15
// act as 8); digits past frac_length_o read as zero. The block takes one
// beat per clock and gives one result beat per input beat, in order.
// An accepted input beat passes to the output through the fraction
// scaling register, seven double dabble stages (8 integer bits and 4
// fraction bits shifted through per stage), and the register for the
// digit count and precision cut. Every stage holds its beat
// under back-pressure and takes a new one as soon as its successor moves,
// so bubbles close up and the throughput stays at one beat per cycle while
// out_ready_i is high. fraction_digits is written through cfg_we_i and
// cfg_wdata_i, resets to 8, and must only change while no beat is in flight.
module fixed_point_to_decimal_digits import fptd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write
  input  logic                     cfg_we_i,
  input  logic [FRAC_LEN_BITS-1:0] cfg_wdata_i,
  // input beat
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [VALUE_BITS-1:0]    value_i,
  // result beat
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [INT_BCD_BITS-1:0]  int_digits_o,
  output logic [INT_LEN_BITS-1:0]  int_length_o,
  output logic [FRAC_BCD_BITS-1:0] frac_digits_o,
  output logic [FRAC_LEN_BITS-1:0] frac_length_o
);

`include "fixed_point_to_decimal_digits_macros.svh"

  // fraction precision register
  logic [FRAC_LEN_BITS-1:0] fraction_digits_q;

  // pipeline links: index 0 is the entry stage output, index DD_STAGES feeds the output stage
  work_t stage_data  [DD_STAGES+1];
  logic  stage_valid [DD_STAGES+1];
  logic  stage_ready [DD_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fraction_digits_q <= FRAC_LEN_BITS'(FRAC_DIGITS);
    end else if (cfg_we_i) begin
      fraction_digits_q <= cfg_wdata_i;
    end
  end

  // split value, scale fraction nibbles
  fptd_frac_scale u_frac_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .value_i (value_i),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .data_o  (stage_data[0])
  );

  // shift-and-add-3 chain for integer and fraction together
  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    fptd_dd_stage u_dd_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .ready_o (stage_ready[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .ready_i (stage_ready[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  // digit count, precision cut, result register
  fptd_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (stage_valid[DD_STAGES]),
    .ready_o       (stage_ready[DD_STAGES]),
    .data_i        (stage_data[DD_STAGES]),
    .frac_cfg_i    (fraction_digits_q),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .int_digits_o  (int_digits_o),
    .int_length_o  (int_length_o),
    .frac_digits_o (frac_digits_o),
    .frac_length_o (frac_length_o)
  );

  // the leading counted digit is nonzero unless the integer part is zero
  `FPTD_ASSERT_SAME(a_int_len_top, out_valid_o && int_length_o > 5'd1, int_digits_o[4*(int_length_o-5'd1) +: 4] != 4'd0, "leading integer digit is zero")
  // no digit is set above the counted integer digits
  `FPTD_ASSERT_SAME(a_int_len_above, out_valid_o && int_length_o >= 5'd1 && int_length_o <= 5'd16, (int_digits_o >> (int_length_o * 4)) == '0, "integer digit above count")
  // fraction digits past the precision are cleared and precision saturates
  `FPTD_ASSERT_SAME(a_frac_cut, out_valid_o, frac_length_o <= 4'd8 && (frac_digits_o & (32'hffff_ffff >> (frac_length_o * 4))) == 32'd0, "fraction digit past precision")
  // an accepted beat leaves the entry stage occupied
  `FPTD_ASSERT_NEXT(a_entry_fill, in_valid_i && in_ready_o, stage_valid[0], "accepted beat lost at entry")

endmodule
